@@ sv/psd_pkg.sv @@
`default_nettype none
package psd_pkg;

	// Default number of directory slots
	localparam int SLOT_COUNT_DEF = 16;

	// Field widths
	localparam int PAGE_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// Request operations
	typedef enum logic {
		OP_GET    = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 3'd0,
		ST_LOAD    = 3'd1,
		ST_FULL    = 3'd2,
		ST_REMOVED = 3'd3,
		ST_ABSENT  = 3'd4
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE    = 1'b0,
		S_RESOLVE = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic resolve;
	} psd_cmd_t;

endpackage
`default_nettype wire

@@ sv/psd_ctrl.sv @@
`default_nettype none
module psd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output psd_pkg::psd_cmd_t      cmd
);
	import psd_pkg::*;

	state_t state_q;
	state_t state_next;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Advance: accept in idle, resolve, then return to idle
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_next = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Drive commands and busy from the state and start
	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.resolve = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_RESOLVE: begin
				busy        = 1'b1;
				cmd.resolve = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/psd_datapath.sv @@
`default_nettype none
module psd_datapath #(
	parameter int SLOT_COUNT = psd_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire psd_pkg::psd_cmd_t             cmd,
	input  wire logic                          operation,
	input  wire logic [psd_pkg::PAGE_W-1:0]    page_id,
	output logic                               done,
	output logic [psd_pkg::STATUS_W-1:0]       status,
	output logic [psd_pkg::SLOT_W-1:0]         slot
);
	import psd_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Directory storage
	logic [SLOT_COUNT-1:0]  valid_q;
	logic [PAGE_W-1:0]      page_q [SLOT_COUNT];

	// Compare stage
	logic                   op_s1;
	logic [PAGE_W-1:0]      page_s1;
	logic [SLOT_COUNT-1:0]  match_s1;
	logic [SLOT_COUNT-1:0]  free_s1;

	// Select results
	logic                   hit_any;
	logic [IDX_W-1:0]       hit_idx;
	logic                   free_any;
	logic [IDX_W-1:0]       free_idx;
	logic                   alloc;
	logic                   drop;
	status_t                status_d;
	logic [IDX_W-1:0]       slot_idx_d;
	logic                   slot_none_d;

	// Output registers
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [SLOT_W-1:0]      slot_q;

	// Capture request and compare against every slot in parallel
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= operation;
			page_s1 <= page_id;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				match_s1[k] <= valid_q[k] && (page_q[k] == page_id);
				free_s1[k]  <= !valid_q[k];
			end
		end
	end

	// Pick the lowest matching and the lowest free slot
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (match_s1[k]) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(k);
			end
			if (free_s1[k]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	// Decide the outcome of the transaction
	always_comb begin
		alloc       = 1'b0;
		drop        = 1'b0;
		status_d    = ST_ABSENT;
		slot_idx_d  = '0;
		slot_none_d = 1'b1;
		if (op_s1 == OP_GET) begin
			if (hit_any) begin
				status_d    = ST_HIT;
				slot_idx_d  = hit_idx;
				slot_none_d = 1'b0;
			end else if (free_any) begin
				alloc       = 1'b1;
				status_d    = ST_LOAD;
				slot_idx_d  = free_idx;
				slot_none_d = 1'b0;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			if (hit_any) begin
				drop        = 1'b1;
				status_d    = ST_REMOVED;
				slot_idx_d  = hit_idx;
				slot_none_d = 1'b0;
			end else begin
				status_d = ST_ABSENT;
			end
		end
	end

	// Update valid marks on allocate or remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.resolve) begin
			if (alloc) begin
				valid_q[free_idx] <= 1'b1;
			end else if (drop) begin
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// Record the page number in a newly claimed slot
	always_ff @(posedge clk) begin
		if (cmd.resolve && alloc) begin
			page_q[free_idx] <= page_s1;
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.resolve;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			status_q <= status_d;
			slot_q   <= slot_none_d ? '0 : SLOT_W'(slot_idx_d);
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule
`default_nettype wire

@@ sv/page_slot_directory_top.sv @@
`default_nettype none
// Fully associative page directory. Pulse start with operation (get or
// remove) and page_id while busy is low; the request is taken at that edge.
// On acceptance page_id is compared against every slot and the matches
// are registered; in the resolve state the lowest matching or lowest free
// slot is picked and the valid marks are updated. The result is registered
// on status and slot, marked by done for exactly one cycle, and must be
// taken then: it is not held back. A new request may be started in the cycle
// that done is high; none is taken while the last is resolved. The valid
// marks clear on reset; slot is zero when status is pool full or not present.
module page_slot_directory_top #(
	parameter int SLOT_COUNT = psd_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic [psd_pkg::PAGE_W-1:0]    page_id,
	output logic                               done,
	output logic [psd_pkg::STATUS_W-1:0]       status,
	output logic [psd_pkg::SLOT_W-1:0]         slot
);
	import psd_pkg::*;

	psd_cmd_t cmd;

	psd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	psd_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.page_id   (page_id),
		.done      (done),
		.status    (status),
		.slot      (slot)
	);

	// An accepted transaction raises done after the resolve state and the done register
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing after accept");

	// Busy follows acceptance
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// The result is delivered only once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// No slot is reported when none was found or free
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL || status == ST_ABSENT)) |-> (slot == '0))
		else $error("nonzero slot with full or absent status");

endmodule
`default_nettype wire

@@ tb/sv/page_directory_checker.sv @@
`timescale 1ns / 100ps
// Watches the request and result ports of the page directory, keeps a
// shadow copy of the slots, and checks every result against the oldest
// prediction still waiting.
module page_directory_checker #(
	parameter int SLOT_COUNT = psd_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic                          operation,
	input  wire logic [psd_pkg::PAGE_W-1:0]    page_id,
	input  wire logic                          done,
	input  wire logic [psd_pkg::STATUS_W-1:0]  status,
	input  wire logic [psd_pkg::SLOT_W-1:0]    slot,
	output int                                 fail_count,
	output int                                 pending
);
	import psd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} directory_answer_t;

	// Shadow directory
	logic              dir_valid [SLOT_COUNT];
	logic [PAGE_W-1:0] dir_page  [SLOT_COUNT];

	directory_answer_t expected_answers [$];
	int                mismatches;

	// Look up the page, then allocate or free a slot as the request asks
	function automatic directory_answer_t resolve_request(op_t op, logic [PAGE_W-1:0] page);
		directory_answer_t answer;
		int match_at;
		int free_at;
		match_at = -1;
		free_at = -1;
		// scan downward so the lowest index wins
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (dir_valid[k] && dir_page[k] == page)
				match_at = k;
			if (!dir_valid[k])
				free_at = k;
		end
		answer.slot = '0;
		if (op == OP_GET) begin
			if (match_at >= 0) begin
				answer.status = ST_HIT;
				answer.slot = match_at[SLOT_W-1:0];
			end else if (free_at >= 0) begin
				dir_valid[free_at] = 1'b1;
				dir_page[free_at] = page;
				answer.status = ST_LOAD;
				answer.slot = free_at[SLOT_W-1:0];
			end else begin
				answer.status = ST_FULL;
			end
		end else begin
			if (match_at >= 0) begin
				// the stored page number stays, only the mark drops
				dir_valid[match_at] = 1'b0;
				answer.status = ST_REMOVED;
				answer.slot = match_at[SLOT_W-1:0];
			end else begin
				answer.status = ST_ABSENT;
			end
		end
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		directory_answer_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOT_COUNT; k++) begin
				dir_valid[k] = 1'b0;
				dir_page[k] = '0;
			end
			expected_answers.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// compare a completed transaction with the oldest prediction
			if (done === 1'b1) begin
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with nothing pending: status %0d slot %0d",
							$time, status, slot);
				end else begin
					want = expected_answers.pop_front();
					if (status !== want.status || slot !== want.slot) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: mismatch: status exp %0d got %0d, slot exp %0d got %0d",
								$time, want.status, status, want.slot, slot);
					end
				end
			end
			// predict the answer for an accepted transaction
			if (start === 1'b1 && busy === 1'b0)
				expected_answers.push_back(resolve_request(op_t'(operation), page_id));
			pending <= expected_answers.size();
			fail_count <= mismatches;
		end
	end

endmodule

@@ tb/sv/page_slot_directory_top_tb.sv @@
`timescale 1ns / 100ps
module page_slot_directory_top_tb;
	import psd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 170;
	localparam int POOL_MAX    = 64;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              operation;
	logic [PAGE_W-1:0] page_id;
	logic              done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot;

	int fail_count;
	int pending;
	int quiet_cycles = 0;

	logic [PAGE_W-1:0] page_pool [POOL_MAX];
	int                pool_size = 1;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	page_slot_directory_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.page_id   (page_id),
		.done      (done),
		.status    (status),
		.slot      (slot)
	);

	page_directory_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.page_id    (page_id),
		.done       (done),
		.status     (status),
		.slot       (slot),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Present one request and hold it until the block takes it
	task automatic send_request(input op_t op, input logic [PAGE_W-1:0] page);
		start <= 1'b1;
		operation <= op;
		page_id <= page;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Drop start, with junk on the request fields, and wait the requested number of clocks
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		operation <= 1'($urandom_range(0, 1));
		page_id <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// Mostly pages from the working set, now and then a stray one
	function automatic logic [PAGE_W-1:0] draw_page();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return page_pool[$urandom_range(0, pool_size - 1)];
	endfunction

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("page_slot_directory_top_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pool_sizes [PHASES] = '{4, 12, 20, 40, 16, 24};
		int get_pct [PHASES] = '{60, 70, 50, 75, 40, 65};
		op_t op;
		arst_n = 1'b0;
		start = 1'b0;
		operation = 1'b0;
		page_id = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// allocate, hit, remove, remove again, remove unknown page
		send_request(OP_GET, 32'h0000_0000);
		send_request(OP_GET, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'h0000_0000);
		send_request(OP_REMOVE, 32'hFFFF_FFFF);
		send_request(OP_REMOVE, 32'hFFFF_FFFF);
		send_request(OP_REMOVE, 32'h1234_5678);
		// fill every slot, then overflow and hit while full
		for (int p = 1; p < 16; p++)
			send_request(OP_GET, p);
		send_request(OP_GET, 32'hA5A5_A5A5);
		send_request(OP_GET, 32'h0000_0000);
		// free a middle slot and reuse it
		send_request(OP_REMOVE, 32'h0000_0007);
		send_request(OP_GET, 32'h5A5A_5A5A);
		send_request(OP_GET, 32'h0000_0007);

		// random phases with varying working set and get/remove mix
		for (int ph = 0; ph < PHASES; ph++) begin
			pool_size = pool_sizes[ph];
			for (int k = 0; k < pool_size; k++)
				page_pool[k] = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph < PHASES - 1 && (n / 40) % 3 != 2 && $urandom_range(0, 5) == 0)
					hold_off($urandom_range(1, 18));
				op = ($urandom_range(1, 100) <= get_pct[ph]) ? OP_GET : OP_REMOVE;
				send_request(op, draw_page());
			end
		end

		// drain outstanding results
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("page_slot_directory_top_tb: clean");
		else
			$display("page_slot_directory_top_tb: errors");
		$finish;
	end

endmodule
